[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Every check is clocked on clk and
// switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pate_pkg.sv]
package pate_pkg;

  localparam int DEPTH_DEFAULT = 64;

  localparam int OP_W     = 3;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_DISPLAY = 3'd0,
    OP_INSERT  = 3'd1,
    OP_DELETE  = 3'd2,
    OP_SEARCH  = 3'd3,
    OP_UPDATE  = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 3'd0,
    ST_FOUND  = 3'd1,
    ST_MISS   = 3'd2,
    ST_BADPOS = 3'd3,
    ST_FULL   = 3'd4
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [VAL_W-1:0] element;
    logic [POS_W-1:0]        where;
    logic [COUNT_W-1:0]      count;
    logic                    last;
  } rsp_t;

endpackage

[hw/rtl/pate_stream_if.sv]
interface pate_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/pate_ram.sv]
module pate_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/positional_array_table_engine_top.sv]
// Channel   Role     Payload                                  Accepted when
// req       sink     op, position, value                      req.valid && req.ready
// rsp       source   status, element, where, count, last      rsp.valid && rsp.ready
//
// One request is worked on at a time; req.ready is high only while the sequencer is idle.
// Insert and delete shift the elements behind the position; an append and the removal of
// the last element move none. Display and search walk the list, reading one element a
// cycle; a display walk does so only while rsp does not stall.
// Reset (rst, synchronous) empties the list; the element memory itself is not cleared.
// A stall on rsp holds the word in the output register and pauses a display walk.

`include "assert_macros.svh"

module positional_array_table_engine_top #(
  parameter int DEPTH = pate_pkg::DEPTH_DEFAULT
) (
  input logic          clk,
  input logic          rst,
  pate_stream_if.sink   req,
  pate_stream_if.source rsp
);

  // Address width of the store, and width of the element count, which must hold DEPTH.
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRIME,
    S_DISP,
    S_SRCH,
    S_SHIFT,
    S_TAIL,
    S_PUT,
    S_EMIT
  } state_t;

  state_t state;

  // Element count and the registered output word.
  logic [CW-1:0]     count;
  logic              out_valid;
  pate_pkg::rsp_t    rsp_q;

  // Request held for the duration of the operation.
  logic [pate_pkg::OP_W-1:0]         op_q;
  logic signed [pate_pkg::VAL_W-1:0] val_q;

  // Walk pointer, the index at which the walk stops, and the write target of an insert
  // or update. During a shift, wptr is where the word read in the previous cycle goes.
  logic [AW-1:0] ptr;
  logic [AW-1:0] stop;
  logic [AW-1:0] tgt;
  logic [AW-1:0] wptr;
  logic          wpend;
  logic          dir_up;

  // Status and position staged for a single-word result.
  logic [pate_pkg::STATUS_W-1:0] res_status;
  logic [pate_pkg::POS_W-1:0]    res_where;

  // Memory port.
  logic                       we;
  logic [AW-1:0]              waddr;
  logic [pate_pkg::VAL_W-1:0] wdata;
  logic [AW-1:0]              raddr;
  logic [pate_pkg::VAL_W-1:0] rdata;

  logic                         slot_free;
  logic                         load_word;
  logic                         accept;
  logic [pate_pkg::POS_W-1:0]   n_ext;
  logic                         full;
  logic                         pos_ok_ins;
  logic                         pos_ok_mod;
  logic [pate_pkg::POS_W-1:0]   ptr_where;

  pate_ram #(
    .WIDTH (pate_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = rsp_q;

  assign accept    = req.valid && req.ready;
  assign slot_free = !out_valid || rsp.ready;

  // A new word enters the output register whenever a result state finds the slot free.
  assign load_word = slot_free && (state == S_DISP || state == S_EMIT);

  // Position checks against the current count, in the width of the position field.
  assign n_ext      = pate_pkg::POS_W'(count);
  assign full       = (count == CW'(DEPTH));
  assign pos_ok_ins = (req.data.position != '0) &&
                      (req.data.position <= n_ext + pate_pkg::POS_W'(1));
  assign pos_ok_mod = (req.data.position != '0) && (req.data.position <= n_ext);
  assign ptr_where  = pate_pkg::POS_W'(ptr) + pate_pkg::POS_W'(1);

  // Memory port steering. Display and search read one ahead so that the next element
  // is ready the cycle after the current one is used.
  always_comb begin
    we    = 1'b0;
    waddr = wptr;
    wdata = rdata;
    raddr = ptr;
    case (state)
      S_SHIFT: begin
        we = wpend;
      end
      S_TAIL: begin
        we = 1'b1;
      end
      S_PUT: begin
        we    = 1'b1;
        waddr = tgt;
        wdata = val_q;
      end
      S_DISP: begin
        raddr = slot_free ? ptr + AW'(1) : ptr;
      end
      S_SRCH: begin
        raddr = ptr + AW'(1);
      end
      default: begin
        raddr = ptr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      wpend     <= 1'b0;
    end else begin
      if (load_word) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q      <= req.data.op;
            val_q     <= req.data.value;
            res_where <= '0;
            wpend     <= 1'b0;
            tgt       <= AW'(req.data.position - pate_pkg::POS_W'(1));
            case (req.data.op)
              pate_pkg::OP_DISPLAY: begin
                if (count == '0) begin
                  res_status <= pate_pkg::ST_DONE;
                  state      <= S_EMIT;
                end else begin
                  ptr   <= '0;
                  stop  <= AW'(count - CW'(1));
                  state <= S_PRIME;
                end
              end
              pate_pkg::OP_INSERT: begin
                if (full) begin
                  res_status <= pate_pkg::ST_FULL;
                  state      <= S_EMIT;
                end else if (!pos_ok_ins) begin
                  res_status <= pate_pkg::ST_BADPOS;
                  state      <= S_EMIT;
                end else if (req.data.position == n_ext + pate_pkg::POS_W'(1)) begin
                  // Appending at the end: nothing to move.
                  state <= S_PUT;
                end else begin
                  ptr    <= AW'(count - CW'(1));
                  stop   <= AW'(req.data.position - pate_pkg::POS_W'(1));
                  dir_up <= 1'b1;
                  state  <= S_SHIFT;
                end
              end
              pate_pkg::OP_DELETE: begin
                if (!pos_ok_mod) begin
                  res_status <= pate_pkg::ST_BADPOS;
                  state      <= S_EMIT;
                end else if (req.data.position == n_ext) begin
                  // Removing the last element only shortens the list.
                  count      <= count - CW'(1);
                  res_status <= pate_pkg::ST_DONE;
                  state      <= S_EMIT;
                end else begin
                  ptr    <= AW'(req.data.position);
                  stop   <= AW'(count - CW'(1));
                  dir_up <= 1'b0;
                  state  <= S_SHIFT;
                end
              end
              pate_pkg::OP_SEARCH: begin
                if (count == '0) begin
                  res_status <= pate_pkg::ST_MISS;
                  state      <= S_EMIT;
                end else begin
                  ptr   <= '0;
                  stop  <= AW'(count - CW'(1));
                  state <= S_PRIME;
                end
              end
              pate_pkg::OP_UPDATE: begin
                if (!pos_ok_mod) begin
                  res_status <= pate_pkg::ST_BADPOS;
                  state      <= S_EMIT;
                end else begin
                  state <= S_PUT;
                end
              end
              default: begin
                res_status <= pate_pkg::ST_BADPOS;
                state      <= S_EMIT;
              end
            endcase
          end
        end

        S_PRIME: begin
          state <= (op_q == pate_pkg::OP_DISPLAY) ? S_DISP : S_SRCH;
        end

        S_DISP: begin
          if (slot_free) begin
            rsp_q.status  <= pate_pkg::ST_DONE;
            rsp_q.element <= rdata;
            rsp_q.where   <= ptr_where;
            rsp_q.count   <= pate_pkg::COUNT_W'(count);
            rsp_q.last    <= (ptr == stop);
            if (ptr == stop) begin
              state <= S_IDLE;
            end else begin
              ptr <= ptr + AW'(1);
            end
          end
        end

        S_SRCH: begin
          if (rdata == val_q) begin
            res_status <= pate_pkg::ST_FOUND;
            res_where  <= ptr_where;
            state      <= S_EMIT;
          end else if (ptr == stop) begin
            res_status <= pate_pkg::ST_MISS;
            state      <= S_EMIT;
          end else begin
            ptr <= ptr + AW'(1);
          end
        end

        S_SHIFT: begin
          // Each cycle reads one element and, after the first, writes the one read in the cycle before.
          wpend <= 1'b1;
          wptr  <= dir_up ? ptr + AW'(1) : ptr - AW'(1);
          if (ptr == stop) begin
            state <= S_TAIL;
          end else begin
            ptr <= dir_up ? ptr - AW'(1) : ptr + AW'(1);
          end
        end

        S_TAIL: begin
          wpend <= 1'b0;
          if (op_q == pate_pkg::OP_INSERT) begin
            state <= S_PUT;
          end else begin
            count      <= count - CW'(1);
            res_status <= pate_pkg::ST_DONE;
            state      <= S_EMIT;
          end
        end

        S_PUT: begin
          if (op_q == pate_pkg::OP_INSERT) begin
            count <= count + CW'(1);
          end
          res_status <= pate_pkg::ST_DONE;
          state      <= S_EMIT;
        end

        S_EMIT: begin
          if (slot_free) begin
            rsp_q.status  <= res_status;
            rsp_q.element <= '0;
            rsp_q.where   <= res_where;
            rsp_q.count   <= pate_pkg::COUNT_W'(count);
            rsp_q.last    <= 1'b1;
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The list never grows beyond the store.
  `ASSERT_SAME(a_count_range, 1'b1, count <= CW'(DEPTH), "element count exceeds depth")

  // Writes land inside the list or on the slot just past its end.
  `ASSERT_SAME(a_write_in_list, we, CW'(waddr) <= count, "store written beyond the list")

  // Only a display walk gives words that are not the last of their request.
  `ASSERT_SAME(a_mid_word_is_display, out_valid && !rsp_q.last,
               rsp_q.status == pate_pkg::ST_DONE && rsp_q.where != '0,
               "non-final word that is not a displayed element")

  // A shift always ends with the write of its last moved element.
  `ASSERT_NEXT(a_shift_ends_in_tail, state == S_SHIFT && ptr == stop, state == S_TAIL,
               "shift did not finish with its tail write")

endmodule
